// File: src/pgs_rle_pkg.sv
package pgs_rle_pkg;

    // parse phase of the coded byte stream
    typedef enum logic [1:0] {
        PH_COLOR      = 2'd0,
        PH_FLAG       = 2'd1,
        PH_LEN_LOW    = 2'd2,
        PH_COLOR_BYTE = 2'd3
    } t_phase;

    // configuration register indexes
    typedef logic [0:0] t_reg_index;
    localparam t_reg_index REG_IMAGE_WIDTH  = 1'd0;
    localparam t_reg_index REG_IMAGE_HEIGHT = 1'd1;

    // configuration reset values
    localparam logic [11:0] WIDTH_RESET  = 12'd1920;
    localparam logic [11:0] HEIGHT_RESET = 12'd1080;

    // flag byte layout
    localparam int unsigned FLAG_LONG_BIT  = 6;
    localparam int unsigned FLAG_COLOR_BIT = 7;
    localparam int unsigned LEN_HIGH_W     = 6;

    // field widths
    localparam int unsigned COORD_W  = 12;
    localparam int unsigned POS_W    = 13;
    localparam int unsigned LENGTH_W = 14;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned S_USER_W = 1;
    localparam int unsigned M_DATA_W = 48;
    localparam int unsigned M_USER_W = 2;

    // one decoded run
    typedef struct packed {
        logic               clipped;
        logic               line_end;
        logic [COORD_W-1:0] length;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [7:0]         color;
    } t_run;

endpackage

// File: src/pgs_object_rle_decoder.sv
// Run-length decoder for presentation-graphics subtitle object bitmaps.
// Slave stream: one coded byte per beat on i_s_axis_tdata; i_s_axis_tuser
// marks the first byte of an object and clears row, column and parse phase
// before that byte is parsed.
// Master stream: one beat per decoded run (palette index, row, start column,
// clipped length) or per end-of-line marker; tuser carries the line-end and
// clipped flags.
// Throughput is one byte per cycle while the skid stage is empty. Each run is
// registered into the output stage (or the skid stage if that is held); bytes
// that finish no run (escape, flag, length and color prefixes) produce no beat.
// The result register is backed by a one-entry skid stage, so o_s_axis_tready
// is a register output and drops only when both are full; under a stalled
// receiver one more run goes into the skid stage and the byte stream stops in
// the cycle after it.
// Reset (synchronous, active low) empties both stages, returns the parser to
// the color phase at row and column zero, and loads image_width 1920 and
// image_height 1080. The user must write the registers through i_cfg_we,
// i_cfg_index and i_cfg_wdata only while the stream is idle; nothing enforces it.
module pgs_object_rle_decoder #(
    parameter int unsigned MAX_DIMENSION = 4095
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  pgs_rle_pkg::t_reg_index             i_cfg_index,
    input  logic [pgs_rle_pkg::COORD_W-1:0]     i_cfg_wdata,
    // coded byte stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [pgs_rle_pkg::S_DATA_W-1:0]    i_s_axis_tdata,  // [7:0] code_byte
    input  logic [pgs_rle_pkg::S_USER_W-1:0]    i_s_axis_tuser,  // [0] object_start
    // decoded run stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] run_color, [19:8] run_row, [31:20] run_column, [43:32] run_length,
    // [47:44] zero
    output logic [pgs_rle_pkg::M_DATA_W-1:0]    o_m_axis_tdata,
    output logic [pgs_rle_pkg::M_USER_W-1:0]    o_m_axis_tuser   // [0] line_end, [1] clipped
);

    localparam int unsigned POS_W    = pgs_rle_pkg::POS_W;
    localparam int unsigned LENGTH_W = pgs_rle_pkg::LENGTH_W;
    localparam int unsigned COORD_W  = pgs_rle_pkg::COORD_W;
    localparam logic [POS_W-1:0] ROW_MAX = POS_W'(MAX_DIMENSION);

    // configuration
    logic [COORD_W-1:0] r_width;
    logic [COORD_W-1:0] r_height;

    // parser state
    pgs_rle_pkg::t_phase r_phase, n_phase;
    logic                r_flag_color, n_flag_color;
    logic [LENGTH_W-1:0] r_pending, n_pending;
    logic [POS_W-1:0]    r_column, n_column;
    logic [POS_W-1:0]    r_row, n_row;

    // output and skid stages
    logic                r_out_valid;
    pgs_rle_pkg::t_run   r_out_run;
    logic                r_skid_valid;
    pgs_rle_pkg::t_run   r_skid_run;

    // state as seen by the current byte
    pgs_rle_pkg::t_phase cur_phase;
    logic                cur_flag_color;
    logic [LENGTH_W-1:0] cur_pending;
    logic [POS_W-1:0]    cur_column;
    logic [POS_W-1:0]    cur_row;

    logic [7:0]          code_byte;
    logic                in_accept;
    logic                out_free;

    // run emission
    logic                do_emit;
    logic                eol;
    logic [7:0]          emit_color;
    logic [LENGTH_W-1:0] emit_len;
    logic                col_past;
    logic [POS_W-1:0]    avail;
    logic [LENGTH_W:0]   run_end;
    logic                past_end;
    logic                row_past;
    logic [COORD_W-1:0]  written;
    logic [POS_W-1:0]    emit_column;
    logic                has_result;
    pgs_rle_pkg::t_run   new_run;

    assign code_byte = i_s_axis_tdata[7:0];
    assign in_accept = i_s_axis_tvalid & o_s_axis_tready;
    assign out_free  = ~r_out_valid | i_m_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pgs_rle_pkg::WIDTH_RESET;
            r_height <= pgs_rle_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pgs_rle_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata;
                pgs_rle_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // object start clears position and phase ahead of the byte
    always_comb begin
        if (i_s_axis_tuser[0]) begin
            cur_phase      = pgs_rle_pkg::PH_COLOR;
            cur_flag_color = 1'b0;
            cur_pending    = '0;
            cur_column     = '0;
            cur_row        = '0;
        end else begin
            cur_phase      = r_phase;
            cur_flag_color = r_flag_color;
            cur_pending    = r_pending;
            cur_column     = r_column;
            cur_row        = r_row;
        end
    end

    // byte parser
    always_comb begin
        n_flag_color = cur_flag_color;
        n_pending    = cur_pending;
        n_row        = cur_row;
        do_emit      = 1'b0;
        eol          = 1'b0;
        emit_color   = '0;
        emit_len     = '0;
        n_phase      = cur_phase;
        unique case (cur_phase)
            pgs_rle_pkg::PH_FLAG: begin
                if (code_byte == 8'd0) begin
                    eol     = 1'b1;
                    n_phase = pgs_rle_pkg::PH_COLOR;
                    if (cur_row < ROW_MAX) begin
                        n_row = cur_row + POS_W'(1);
                    end
                end else begin
                    n_flag_color = code_byte[pgs_rle_pkg::FLAG_COLOR_BIT];
                    n_pending    = LENGTH_W'(code_byte[pgs_rle_pkg::LEN_HIGH_W-1:0]);
                    if (code_byte[pgs_rle_pkg::FLAG_LONG_BIT]) begin
                        n_phase = pgs_rle_pkg::PH_LEN_LOW;
                    end else if (code_byte[pgs_rle_pkg::FLAG_COLOR_BIT]) begin
                        n_phase = pgs_rle_pkg::PH_COLOR_BYTE;
                    end else begin
                        do_emit  = 1'b1;
                        emit_len = LENGTH_W'(code_byte[pgs_rle_pkg::LEN_HIGH_W-1:0]);
                    end
                end
            end
            pgs_rle_pkg::PH_LEN_LOW: begin
                n_pending = {cur_pending[pgs_rle_pkg::LEN_HIGH_W-1:0], code_byte};
                if (cur_flag_color) begin
                    n_phase = pgs_rle_pkg::PH_COLOR_BYTE;
                end else begin
                    do_emit  = 1'b1;
                    emit_len = {cur_pending[pgs_rle_pkg::LEN_HIGH_W-1:0], code_byte};
                end
            end
            pgs_rle_pkg::PH_COLOR_BYTE: begin
                do_emit    = 1'b1;
                emit_color = code_byte;
                emit_len   = cur_pending;
            end
            default: begin
                if (code_byte == 8'd0) begin
                    n_phase = pgs_rle_pkg::PH_FLAG;
                end else begin
                    do_emit    = 1'b1;
                    emit_color = code_byte;
                    emit_len   = LENGTH_W'(1);
                end
            end
        endcase
        if (do_emit) begin
            n_phase = pgs_rle_pkg::PH_COLOR;
        end
    end

    // clipping of the run against row end and height
    always_comb begin
        col_past = cur_column >= {1'b0, r_width};
        avail    = {1'b0, r_width} - cur_column;
        run_end  = {2'b00, cur_column} + {1'b0, emit_len};
        past_end = run_end > {3'b000, r_width};
        row_past = cur_row >= {1'b0, r_height};
        if (col_past || row_past) begin
            written = '0;
        end else if ({1'b0, emit_len} > {2'b00, avail}) begin
            written = avail[COORD_W-1:0];
        end else begin
            written = emit_len[COORD_W-1:0];
        end
        if (past_end) begin
            emit_column = col_past ? cur_column : {1'b0, r_width};
        end else begin
            emit_column = run_end[POS_W-1:0];
        end
        if (eol) begin
            n_column = '0;
        end else if (do_emit) begin
            n_column = emit_column;
        end else begin
            n_column = cur_column;
        end
    end

    // result beat
    always_comb begin
        has_result       = do_emit | eol;
        new_run.color    = eol ? 8'd0 : emit_color;
        new_run.row      = cur_row[COORD_W-1:0];
        new_run.column   = cur_column[COORD_W-1:0];
        new_run.length   = eol ? '0 : written;
        new_run.line_end = eol;
        new_run.clipped  = eol ? row_past : (past_end | row_past);
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= pgs_rle_pkg::PH_COLOR;
            r_flag_color <= 1'b0;
            r_pending    <= '0;
            r_column     <= '0;
            r_row        <= '0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_flag_color <= n_flag_color;
            r_pending    <= n_pending;
            r_column     <= n_column;
            r_row        <= n_row;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept && has_result) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out_run <= r_skid_run;
            end
        end else if (in_accept && has_result) begin
            if (out_free) begin
                r_out_run <= new_run;
            end else begin
                r_skid_run <= new_run;
            end
        end
    end

    assign o_s_axis_tready = ~r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_run.length, r_out_run.column,
                              r_out_run.row, r_out_run.color};
    assign o_m_axis_tuser  = {r_out_run.clipped, r_out_run.line_end};

    // skid stage only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while output stage empty");

    // end-of-line beats carry no pixels
    a_eol_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
            (o_m_axis_tdata[7:0] == 8'd0 && o_m_axis_tdata[43:32] == 12'd0))
        else $error("end-of-line beat with color or length");

    // column stays within the 12-bit window
    a_column_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column[POS_W-1] == 1'b0)
        else $error("column counter beyond window");

    // row counter saturates
    a_row_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_MAX)
        else $error("row counter past saturation value");

    // an escape byte moves the parser to the flag phase
    a_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && cur_phase == pgs_rle_pkg::PH_COLOR && code_byte == 8'd0)
            |=> (r_phase == pgs_rle_pkg::PH_FLAG))
        else $error("escape byte did not enter flag phase");

endmodule

// File: test/pgs_object_rle_decoder_test.sv
module pgs_object_rle_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pgs_rle_pkg::*;

    localparam int unsigned HALF_PERIOD   = 5;
    localparam int unsigned ROW_LIMIT     = 4095;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned GAP_PERCENT   = 7;
    localparam int unsigned PRINT_CAP     = 200;
    localparam int unsigned PHASE_BYTES   = 130;
    localparam int unsigned LINE_BURST    = 30;
    localparam logic [7:0]  ESCAPE_BYTE   = 8'h00;
    localparam logic [7:0]  LINE_END_FLAG = 8'h00;

    // one coded byte waiting to be sent
    typedef struct {
        logic [7:0] code;
        logic       first;
    } t_code_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_reg_index            i_cfg_index = REG_IMAGE_WIDTH;
    logic [COORD_W-1:0]    i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_DATA_W-1:0]   i_s_axis_tdata = '0;   // [7:0] code_byte
    logic [S_USER_W-1:0]   i_s_axis_tuser = '0;   // [0] object_start
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [7:0] run_color, [19:8] run_row, [31:20] run_column, [43:32] run_length
    logic [M_DATA_W-1:0]   o_m_axis_tdata;
    logic [M_USER_W-1:0]   o_m_axis_tuser;        // [0] line_end, [1] clipped

    // stimulus and scoreboard
    t_code_beat            pending_beats[$];
    t_run                  expected_runs[$];
    logic                  byte_taken = 1'b0;
    logic                  idle_gaps = 1'b1;
    int unsigned           bytes_queued = 0;
    int unsigned           bytes_taken = 0;
    int unsigned           runs_checked = 0;
    int unsigned           lines_seen = 0;
    int unsigned           clipped_seen = 0;
    int unsigned           mismatches = 0;

    // decoder state mirror, starts at its reset values
    t_phase                parse_state = PH_COLOR;
    logic [1:0]            flag_hold = '0;
    logic [LENGTH_W-1:0]   run_len_acc = '0;
    logic [POS_W-1:0]      at_column = '0;
    logic [POS_W-1:0]      at_row = '0;
    logic [COORD_W-1:0]    cfg_width = WIDTH_RESET;
    logic [COORD_W-1:0]    cfg_height = HEIGHT_RESET;

    pgs_object_rle_decoder #(
        .MAX_DIMENSION(ROW_LIMIT)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // one mismatch line, printing capped so a broken block cannot flood the log
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
    endtask

    // finished run: clip to the row end, blank rows past the height
    task automatic emit_run(input logic [7:0] color, input logic [LENGTH_W-1:0] len);
        int unsigned start_col;
        int unsigned row_w;
        int unsigned written;
        int unsigned stop_col;
        logic        clip;
        t_run        run;
        start_col = at_column;
        row_w     = cfg_width;
        stop_col  = start_col + len;
        clip      = 1'b0;
        if (start_col >= row_w) begin
            written = 0;
        end else if (len > row_w - start_col) begin
            written = row_w - start_col;
        end else begin
            written = len;
        end
        if (stop_col > row_w) begin
            clip     = 1'b1;
            stop_col = (start_col > row_w) ? start_col : row_w;
        end
        if (at_row >= cfg_height) begin
            clip    = 1'b1;
            written = 0;
        end
        at_column   = stop_col[POS_W-1:0];
        parse_state = PH_COLOR;
        run          = '0;
        run.color    = color;
        run.row      = at_row[COORD_W-1:0];
        run.column   = start_col[COORD_W-1:0];
        run.length   = written[COORD_W-1:0];
        run.clipped  = clip;
        expected_runs.push_back(run);
    endtask

    // parse one accepted code byte
    task automatic decode_byte(input logic [7:0] code, input logic first);
        t_run eol;
        if (first) begin
            parse_state = PH_COLOR;
            flag_hold   = '0;
            run_len_acc = '0;
            at_column   = '0;
            at_row      = '0;
        end
        case (parse_state)
            PH_FLAG: begin
                if (code == LINE_END_FLAG) begin
                    eol          = '0;
                    eol.row      = at_row[COORD_W-1:0];
                    eol.column   = at_column[COORD_W-1:0];
                    eol.line_end = 1'b1;
                    eol.clipped  = (at_row >= cfg_height);
                    expected_runs.push_back(eol);
                    if (at_row < ROW_LIMIT) begin
                        at_row++;
                    end
                    at_column   = '0;
                    parse_state = PH_COLOR;
                end else begin
                    flag_hold   = code[FLAG_COLOR_BIT:FLAG_LONG_BIT];
                    run_len_acc = LENGTH_W'(code[LEN_HIGH_W-1:0]);
                    if (code[FLAG_LONG_BIT]) begin
                        parse_state = PH_LEN_LOW;
                    end else if (code[FLAG_COLOR_BIT]) begin
                        parse_state = PH_COLOR_BYTE;
                    end else begin
                        emit_run(8'd0, run_len_acc);
                    end
                end
            end
            PH_LEN_LOW: begin
                run_len_acc = {run_len_acc[LEN_HIGH_W-1:0], code};
                if (flag_hold[1]) begin
                    parse_state = PH_COLOR_BYTE;
                end else begin
                    emit_run(8'd0, run_len_acc);
                end
            end
            PH_COLOR_BYTE: begin
                emit_run(code, run_len_acc);
            end
            default: begin
                if (code == ESCAPE_BYTE) begin
                    parse_state = PH_FLAG;
                end else begin
                    emit_run(code, LENGTH_W'(1));
                end
            end
        endcase
    endtask

    // compare one output beat against the oldest predicted run
    task automatic check_run(input logic [M_DATA_W-1:0] data, input logic [M_USER_W-1:0] user);
        t_run want;
        if (expected_runs.size() == 0) begin
            report_mismatch("run beat with nothing pending", data[7:0], 0);
            return;
        end
        want = expected_runs.pop_front();
        runs_checked++;
        if (want.line_end) lines_seen++;
        if (want.clipped) clipped_seen++;
        if (data[7:0] != want.color)    report_mismatch("run_color", data[7:0], want.color);
        if (data[19:8] != want.row)     report_mismatch("run_row", data[19:8], want.row);
        if (data[31:20] != want.column) report_mismatch("run_column", data[31:20], want.column);
        if (data[43:32] != want.length) report_mismatch("run_length", data[43:32], want.length);
        if (user[0] != want.line_end)   report_mismatch("line_end", user[0], want.line_end);
        if (user[1] != want.clipped)    report_mismatch("clipped", user[1], want.clipped);
    endtask

    function automatic void push_beat(input logic [7:0] code, input logic first);
        t_code_beat nb;
        nb.code  = code;
        nb.first = first;
        pending_beats.push_back(nb);
        bytes_queued++;
    endfunction

    function automatic logic [7:0] flag_byte(input logic long_len, input logic has_color,
                                             input logic [LEN_HIGH_W-1:0] len_high);
        logic [7:0] f;
        f                 = 8'(len_high);
        f[FLAG_LONG_BIT]  = long_len;
        f[FLAG_COLOR_BIT] = has_color;
        return f;
    endfunction

    // one well-formed code sequence with random content, or a stray byte
    task automatic add_random_sequence(input logic force_start);
        logic                first;
        logic                with_color;
        int unsigned         pick;
        logic [LENGTH_W-1:0] len;
        logic [7:0]          color;
        first      = force_start || ($urandom_range(0, 99) < 3);
        pick       = $urandom_range(0, 99);
        len        = ($urandom_range(0, 3) == 0) ? LENGTH_W'($urandom_range(0, 16383))
                                                 : LENGTH_W'($urandom_range(0, 255));
        color      = 8'($urandom_range(0, 255));
        with_color = 1'($urandom_range(0, 1));
        if (pick < 35) begin
            push_beat(8'($urandom_range(1, 255)), first);
        end else if (pick < 55) begin
            push_beat(ESCAPE_BYTE, first);
            push_beat(flag_byte(1'b0, 1'b0, LEN_HIGH_W'($urandom_range(1, 63))), 1'b0);
        end else if (pick < 70) begin
            push_beat(ESCAPE_BYTE, first);
            push_beat(flag_byte(1'b0, 1'b1, LEN_HIGH_W'($urandom_range(0, 63))), 1'b0);
            push_beat(color, 1'b0);
        end else if (pick < 82) begin
            push_beat(ESCAPE_BYTE, first);
            push_beat(flag_byte(1'b1, with_color, len[LENGTH_W-1:8]), 1'b0);
            push_beat(len[7:0], 1'b0);
            if (with_color) push_beat(color, 1'b0);
        end else if (pick < 92) begin
            push_beat(ESCAPE_BYTE, first);
            push_beat(LINE_END_FLAG, 1'b0);
        end else begin
            push_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic write_register(input t_reg_index idx, input logic [COORD_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) begin
            cfg_width = value;
        end else begin
            cfg_height = value;
        end
    endtask

    // hold off until every byte is in and every run is out, then let the pipe settle
    task automatic wait_for_drain();
        do begin
            @(negedge i_clk);
        end while (bytes_taken != bytes_queued || expected_runs.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // code byte driver
    always @(negedge i_clk) begin
        t_code_beat nb;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || byte_taken) begin
            if (pending_beats.size() != 0 &&
                !(idle_gaps && $urandom_range(0, 99) < GAP_PERCENT)) begin
                nb = pending_beats.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= nb.code;
                i_s_axis_tuser  <= nb.first;
            end else begin
                i_s_axis_tvalid <= 1'b0;
                i_s_axis_tdata  <= 8'($urandom_range(0, 255));
                i_s_axis_tuser  <= 1'b0;
            end
        end
    end

    // run receiver back-pressure
    always @(negedge i_clk) begin
        i_m_axis_tready <= i_rst_n && !(idle_gaps && $urandom_range(0, 99) < GAP_PERCENT);
    end

    // monitor: check the output beat first, then predict from the input beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_run(o_m_axis_tdata, o_m_axis_tuser);
            end
            byte_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                bytes_taken++;
                decode_byte(i_s_axis_tdata, i_s_axis_tuser[0]);
            end
        end
    end

    // run limit
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        int unsigned        target;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: single pixels, short, explicit color, long and empty runs
        push_beat(8'hFF, 1'b1);
        push_beat(8'h01, 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(flag_byte(1'b0, 1'b0, 6'h3F), 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(flag_byte(1'b0, 1'b1, 6'h3F), 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(flag_byte(1'b1, 1'b0, 6'h3F), 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(flag_byte(1'b1, 1'b1, 6'h3F), 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hAA, 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(LINE_END_FLAG, 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(flag_byte(1'b0, 1'b1, 6'h00), 1'b0);
        push_beat(8'h55, 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(flag_byte(1'b1, 1'b0, 6'h00), 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(LINE_END_FLAG, 1'b0);
        wait_for_drain();

        // one by one window: pixel past the row end, rows past the height
        write_register(REG_IMAGE_WIDTH, 12'd1);
        write_register(REG_IMAGE_HEIGHT, 12'd1);
        push_beat(8'h07, 1'b1);
        push_beat(8'h08, 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(LINE_END_FLAG, 1'b0);
        push_beat(8'h09, 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(flag_byte(1'b0, 1'b0, 6'h05), 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(LINE_END_FLAG, 1'b0);
        wait_for_drain();

        // full size window: exact row fill, empty run at the row end, restart mid-escape
        write_register(REG_IMAGE_WIDTH, 12'd4095);
        write_register(REG_IMAGE_HEIGHT, 12'd4095);
        push_beat(ESCAPE_BYTE, 1'b1);
        push_beat(flag_byte(1'b1, 1'b0, 6'h0F), 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h22, 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(flag_byte(1'b1, 1'b1, 6'h00), 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'h33, 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(8'h44, 1'b1);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(LINE_END_FLAG, 1'b0);
        wait_for_drain();

        // empty window: everything clipped
        write_register(REG_IMAGE_WIDTH, 12'd0);
        write_register(REG_IMAGE_HEIGHT, 12'd0);
        push_beat(8'h10, 1'b1);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(flag_byte(1'b0, 1'b0, 6'h10), 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(LINE_END_FLAG, 1'b0);
        wait_for_drain();

        // random objects over a spread of window sizes, one stretch with no gaps
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin w = 12'd1;    h = 12'd4095; end
                1: begin w = 12'd4095; h = 12'd1;    end
                2: begin
                    w = COORD_W'($urandom_range(1, 64));
                    h = COORD_W'($urandom_range(1, 8));
                end
                3: begin
                    w = COORD_W'($urandom_range(1, 4095));
                    h = COORD_W'($urandom_range(1, 4095));
                end
                4: begin
                    w = COORD_W'($urandom_range(8, 200));
                    h = COORD_W'($urandom_range(2, 20));
                end
                default: begin w = WIDTH_RESET; h = HEIGHT_RESET; end
            endcase
            write_register(REG_IMAGE_WIDTH, w);
            write_register(REG_IMAGE_HEIGHT, h);
            idle_gaps = (ph != 3);
            target = bytes_queued + PHASE_BYTES;
            add_random_sequence(1'b1);
            while (bytes_queued < target) add_random_sequence(1'b0);
            wait_for_drain();
        end
        idle_gaps = 1'b1;

        // a burst of line ends that carries the rows past the height
        write_register(REG_IMAGE_WIDTH, 12'd16);
        write_register(REG_IMAGE_HEIGHT, 12'd12);
        push_beat(8'h5A, 1'b1);
        repeat (LINE_BURST) begin
            push_beat(ESCAPE_BYTE, 1'b0);
            push_beat(LINE_END_FLAG, 1'b0);
        end
        push_beat(8'hA5, 1'b0);
        push_beat(ESCAPE_BYTE, 1'b0);
        push_beat(flag_byte(1'b0, 1'b0, 6'h03), 1'b0);
        wait_for_drain();

        $display("%0d code bytes decoded, %0d runs checked (%0d line ends, %0d clipped)",
                 bytes_taken, runs_checked, lines_seen, clipped_seen);
        $display("windows from empty to 4095x4095, rows carried past the window height");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/pgs_rle_pkg.sv
src/pgs_object_rle_decoder.sv
test/pgs_object_rle_decoder_test.sv
